### design/bb3_pkg.sv
package bb3_pkg;

  localparam int CHANNEL_BITS = 8;
  localparam int PIXEL_BITS = 3 * CHANNEL_BITS;
  localparam int DEFAULT_MAX_WIDTH = 1024;

  localparam int FRAME_WIDTH_BITS = 11;
  localparam int ROW_BITS = 13;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS = 13;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_WIDTH = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_HEIGHT = 1'd1;

  localparam logic [FRAME_WIDTH_BITS-1:0] RESET_FRAME_WIDTH = 11'd1024;
  localparam logic [ROW_BITS-1:0] RESET_FRAME_HEIGHT = 13'd768;
  localparam logic [ROW_BITS-1:0] HEIGHT_LIMIT = 13'd4096;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam int SUM_BITS = 12;
  localparam int COUNT_BITS = 4;
  localparam int NUMER_BITS = 13;
  localparam int RECIP_BITS = 18;
  localparam int RECIP_SHIFT = 18;
  localparam int PROD_BITS = NUMER_BITS + RECIP_BITS;

  typedef logic [CHANNEL_BITS-1:0] chan_t;
  typedef chan_t [2:0] pixel_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WORK,
    ST_SUM,
    ST_DIV
  } state_t;

  // Rounded mean is floor((2*sum + n) / (2*n)); this gives ceil(2^18 / (2*n)),
  // which is exact for every numerator below 2^13.
  function automatic logic [RECIP_BITS-1:0] recip_for(input logic [COUNT_BITS-1:0] n);
    logic [RECIP_BITS-1:0] m;
    unique case (n)
      4'd1: m = 18'd131072;
      4'd2: m = 18'd65536;
      4'd3: m = 18'd43691;
      4'd4: m = 18'd32768;
      4'd6: m = 18'd21846;
      4'd9: m = 18'd14564;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

### design/bb3_ram.sv
module bb3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/box_blur_3x3_rgb.sv
// 3x3 box blur over RGB pixels streamed in raster order.
// Requests enter on in_valid/in_ready: operation selects a pixel or a flush
// item; after the W*H pixels of a frame the sender issues W+1 flush requests.
// Blurred pixels leave on out_valid/out_ready in raster order, with frame_end
// set on the last pixel of the frame. Each output is the rounded mean of the
// 3x3 neighborhood clipped to the image.
// Configuration writes on cfg_valid/cfg_ready (always ready) set the frame
// width and height and restart the frame position; write only while idle.
// A request that yields no pixel only reads and updates the line store; one that
// yields a pixel goes on through the window sum and the rounding multiply. These
// steps run one after the other for one request at a time; the rounded result is
// then registered at the output. The output register lets the next request be accepted
// while a result waits; if the receiver still holds off when the next result
// is ready, the block waits with that result and accepts nothing.
// Reset restores 1024x768, clears the window and the frame position. The line
// store is not cleared; entries are always written before they are used.
module box_blur_3x3_rgb
  import bb3_pkg::*;
#(
  parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      operation,
  input  logic [CHANNEL_BITS-1:0]   in_red,
  input  logic [CHANNEL_BITS-1:0]   in_green,
  input  logic [CHANNEL_BITS-1:0]   in_blue,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [CHANNEL_BITS-1:0]   out_red,
  output logic [CHANNEL_BITS-1:0]   out_green,
  output logic [CHANNEL_BITS-1:0]   out_blue,
  output logic                      frame_end
);

  localparam int XW = $clog2(MAX_WIDTH);

  state_t state, state_next;

  logic [FRAME_WIDTH_BITS-1:0] frame_width;
  logic [ROW_BITS-1:0]         frame_height;
  logic [XW-1:0]               col;
  logic [ROW_BITS-1:0]         row;

  logic [XW-1:0]       w_last;
  logic [ROW_BITS-1:0] h_used;
  logic [XW-1:0]       x_eff;
  logic                res_a, res_b, restart, accept, mem_we, load_out;
  logic [XW-1:0]       col_next;
  logic [ROW_BITS-1:0] row_next;

  pixel_t        pixel;
  logic [XW-1:0] wr_addr;
  logic          res_pending, use_left, use_right, use_top, use_bottom, res_last;

  pixel_t window [3][3];
  logic [2*PIXEL_BITS-1:0] rd_data;
  pixel_t rd_older, rd_recent;

  logic [2:0]            col_use, row_use;
  logic [1:0]            n_cols, n_rows;
  logic [COUNT_BITS-1:0] n_used;
  logic [SUM_BITS-1:0]   sum_w [3];
  logic [NUMER_BITS-1:0] numer [3];
  logic [RECIP_BITS-1:0] recip;
  logic [PROD_BITS-1:0]  prod [3];

  assign cfg_ready = 1'b1;
  assign accept = in_valid && in_ready;

  always_comb begin
    if (frame_width == '0) begin
      w_last = '0;
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w_last = XW'(MAX_WIDTH - 1);
    end else begin
      w_last = XW'(frame_width - FRAME_WIDTH_BITS'(1));
    end
    if (frame_height == '0) begin
      h_used = ROW_BITS'(1);
    end else if (frame_height > HEIGHT_LIMIT) begin
      h_used = HEIGHT_LIMIT;
    end else begin
      h_used = frame_height;
    end
  end

  // Column zero finishes the last pixel of the row two above; any other
  // column finishes the pixel to its left in the row above.
  always_comb begin
    x_eff = (col > w_last) ? '0 : col;
    res_a = (x_eff == '0) && (row >= ROW_BITS'(2));
    res_b = (x_eff != '0) && (row != '0);
    restart = (x_eff == '0) && (row > h_used);
    if (restart) begin
      col_next = '0;
      row_next = '0;
    end else if (x_eff == w_last) begin
      col_next = '0;
      row_next = row + ROW_BITS'(1);
    end else begin
      col_next = x_eff + XW'(1);
      row_next = row;
    end
  end

  always_comb begin
    state_next = state;
    in_ready = 1'b0;
    mem_we = 1'b0;
    load_out = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_WORK;
        end
      end
      ST_WORK: begin
        mem_we = 1'b1;
        state_next = res_pending ? ST_SUM : ST_IDLE;
      end
      ST_SUM: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (!out_valid || out_ready) begin
          load_out = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= RESET_FRAME_WIDTH;
      frame_height <= RESET_FRAME_HEIGHT;
      col <= '0;
      row <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH: frame_width <= cfg_data[FRAME_WIDTH_BITS-1:0];
        CFG_FRAME_HEIGHT: frame_height <= cfg_data[ROW_BITS-1:0];
        default: frame_width <= frame_width;
      endcase
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pixel <= (operation == OP_PIXEL) ? pixel_t'({in_red, in_green, in_blue}) : '0;
      wr_addr <= x_eff;
      res_pending <= res_a || res_b;
      use_left <= res_a ? (w_last != '0) : (x_eff >= XW'(2));
      use_right <= res_b;
      use_top <= res_a ? (row >= ROW_BITS'(3)) : (row >= ROW_BITS'(2));
      use_bottom <= res_a ? (row <= h_used) : (row < h_used);
      res_last <= res_a && (row == h_used + ROW_BITS'(1));
    end
  end

  bb3_ram #(
    .WIDTH(2 * PIXEL_BITS),
    .DEPTH(MAX_WIDTH)
  ) u_line_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(wr_addr),
    .wdata({rd_recent, pixel}),
    .raddr(x_eff),
    .rdata(rd_data)
  );

  assign rd_older = rd_data[2*PIXEL_BITS-1:PIXEL_BITS];
  assign rd_recent = rd_data[PIXEL_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          window[c][r] <= '0;
        end
      end
    end else if (mem_we) begin
      window[0] <= window[1];
      window[1] <= window[2];
      window[2][0] <= rd_older;
      window[2][1] <= rd_recent;
      window[2][2] <= pixel;
    end
  end

  always_comb begin
    col_use = {use_right, 1'b1, use_left};
    row_use = {use_bottom, 1'b1, use_top};
    n_cols = 2'd1 + 2'(use_left) + 2'(use_right);
    n_rows = 2'd1 + 2'(use_top) + 2'(use_bottom);
    n_used = COUNT_BITS'(n_cols) * COUNT_BITS'(n_rows);
    for (int ch = 0; ch < 3; ch++) begin
      sum_w[ch] = '0;
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          if (col_use[c] && row_use[r]) begin
            sum_w[ch] = sum_w[ch] + SUM_BITS'(window[c][r][ch]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SUM) begin
      for (int ch = 0; ch < 3; ch++) begin
        numer[ch] <= {sum_w[ch], 1'b0} + NUMER_BITS'(n_used);
      end
      recip <= recip_for(n_used);
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = PROD_BITS'(numer[ch]) * PROD_BITS'(recip);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_red <= prod[2][RECIP_SHIFT +: CHANNEL_BITS];
      out_green <= prod[1][RECIP_SHIFT +: CHANNEL_BITS];
      out_blue <= prod[0][RECIP_SHIFT +: CHANNEL_BITS];
      frame_end <= res_last;
    end
  end

`ifndef NO_ASSERTIONS
  a_work_after_accept: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WORK) |-> $past(in_valid && in_ready))
    else $error("line store update without an accepted request");

  a_out_from_div: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DIV))
    else $error("result appeared outside the rounding step");

  a_div_after_sum: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> ($past(state == ST_SUM) || $past(state == ST_DIV)))
    else $error("rounding step entered without a window sum");
`endif

endmodule

### verif/box_blur_3x3_rgb_tb.sv
module box_blur_3x3_rgb_tb;
  import bb3_pkg::*;

  typedef struct {
    pixel_t color;
    logic   last;
  } blurred_t;

  // Keeps its own copy of the line stores, the 3x3 window and the frame
  // position, and queues the blurred pixel that each request releases.
  class blur_scoreboard;
    pixel_t older_row[DEFAULT_MAX_WIDTH];
    pixel_t recent_row[DEFAULT_MAX_WIDTH];
    pixel_t window[3][3];
    int unsigned column, row, emitted;
    logic [FRAME_WIDTH_BITS-1:0] width_reg;
    logic [ROW_BITS-1:0] height_reg;
    blurred_t expected_pixels[$];
    int unsigned failures;

    function new();
      foreach (older_row[i]) begin
        older_row[i] = '0;
        recent_row[i] = '0;
      end
      foreach (window[i, j]) window[i][j] = '0;
      width_reg = RESET_FRAME_WIDTH;
      height_reg = RESET_FRAME_HEIGHT;
      column = 0;
      row = 0;
      emitted = 0;
      failures = 0;
    endfunction

    function int unsigned active_width();
      int unsigned w;
      w = width_reg;
      if (w == 0) w = 1;
      if (w > DEFAULT_MAX_WIDTH) w = DEFAULT_MAX_WIDTH;
      return w;
    endfunction

    function int unsigned active_height();
      int unsigned h;
      h = height_reg;
      if (h == 0) h = 1;
      if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
      return h;
    endfunction

    function void write_register(logic [CFG_INDEX_BITS-1:0] index,
                                 logic [CFG_DATA_BITS-1:0] data);
      case (index)
        CFG_FRAME_WIDTH: width_reg = data[FRAME_WIDTH_BITS-1:0];
        CFG_FRAME_HEIGHT: height_reg = data[ROW_BITS-1:0];
        default: ;
      endcase
      column = 0;
      row = 0;
      emitted = 0;
    endfunction

    // Rounded mean over the chosen window columns (negative means skipped).
    function blurred_t blur_window(int left, int center, int right, bit top, bit bottom,
                                   bit last);
      int cols[3];
      int unsigned sum, n;
      blurred_t res;
      cols = '{left, center, right};
      for (int ch = 0; ch < 3; ch++) begin
        sum = 0;
        n = 0;
        for (int k = 0; k < 3; k++) begin
          if (cols[k] < 0) continue;
          for (int rw = 0; rw < 3; rw++) begin
            if (rw == 0 && !top) continue;
            if (rw == 2 && !bottom) continue;
            sum += window[cols[k]][rw][ch];
            n++;
          end
        end
        res.color[ch] = chan_t'((2 * sum + n) / (2 * n));
      end
      res.last = last;
      return res;
    endfunction

    function void note_request(logic op, chan_t red, chan_t green, chan_t blue);
      int unsigned w, h, total, x, y;
      pixel_t pix;
      w = active_width();
      h = active_height();
      total = w * h;
      x = column;
      y = row;
      if (x >= w) x = 0;
      pix = (op == OP_PIXEL) ? {red, green, blue} : '0;
      if (x == 0 && y >= 2 && emitted < total) begin
        expected_pixels.push_back(blur_window(w >= 2 ? 1 : -1, 2, -1, y >= 3, y - 1 < h,
                                              emitted + 1 == total));
        emitted++;
      end
      for (int rw = 0; rw < 3; rw++) begin
        window[0][rw] = window[1][rw];
        window[1][rw] = window[2][rw];
      end
      window[2][0] = older_row[x];
      window[2][1] = recent_row[x];
      window[2][2] = pix;
      older_row[x] = recent_row[x];
      recent_row[x] = pix;
      if (x >= 1 && y >= 1 && emitted < total) begin
        expected_pixels.push_back(blur_window(x >= 2 ? 0 : -1, 1, 2, y >= 2, y < h,
                                              emitted + 1 == total));
        emitted++;
      end
      if (x == 0 && y >= h + 1) begin
        column = 0;
        row = 0;
        emitted = 0;
      end else begin
        x++;
        if (x >= w) begin
          x = 0;
          y++;
        end
        column = x;
        row = y;
      end
    endfunction

    function void check_pixel(chan_t red, chan_t green, chan_t blue, logic last);
      blurred_t want;
      if (expected_pixels.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("output pixel with no request pending: r=%0d g=%0d b=%0d end=%0b",
                   red, green, blue, last);
        return;
      end
      want = expected_pixels.pop_front();
      if (want.color[2] !== red || want.color[1] !== green || want.color[0] !== blue ||
          want.last !== last) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: want r=%0d g=%0d b=%0d end=%0b, got r=%0d g=%0d b=%0d end=%0b",
                   want.color[2], want.color[1], want.color[0], want.last,
                   red, green, blue, last);
      end
    endfunction

    function void report_leftovers();
      if (expected_pixels.size() != 0) begin
        failures += expected_pixels.size();
        $display("%0d expected pixels never arrived", expected_pixels.size());
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic operation;
  chan_t in_red, in_green, in_blue;
  logic out_valid;
  logic out_ready;
  chan_t out_red, out_green, out_blue;
  logic frame_end;

  blur_scoreboard sb;
  bit steady;
  int unsigned items_sent;
  int unsigned cur_w, cur_h;
  int unsigned hold_requests;

  box_blur_3x3_rgb i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .frame_end (frame_end)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_register(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.note_request(operation, in_red, in_green, in_blue);
      if (out_valid && out_ready) sb.check_pixel(out_red, out_green, out_blue, frame_end);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [FRAME_WIDTH_BITS-1:0] pick_width();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return FRAME_WIDTH_BITS'($urandom_range(9, 40));
    return FRAME_WIDTH_BITS'($urandom_range(1, 8));
  endfunction

  function automatic logic [ROW_BITS-1:0] pick_height();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return ROW_BITS'($urandom_range(8, 12));
    return ROW_BITS'($urandom_range(1, 6));
  endfunction

  task automatic send_item(logic op, chan_t red, chan_t green, chan_t blue);
    int unsigned gap;
    in_valid <= 1'b1;
    operation <= op;
    in_red <= red;
    in_green <= green;
    in_blue <= blue;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    int unsigned cycles;
    cycles = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_pixels.size() != 0 && cycles < 20000) begin
      @(posedge clk);
      cycles++;
    end
    repeat (10) @(posedge clk);
  endtask

  task automatic configure(bit set_width, logic [FRAME_WIDTH_BITS-1:0] width,
                           bit set_height, logic [ROW_BITS-1:0] height);
    logic [CFG_DATA_BITS-1:0] word;
    if (set_width) begin
      word = CFG_DATA_BITS'($urandom);
      word[FRAME_WIDTH_BITS-1:0] = width;
      cfg_valid <= 1'b1;
      cfg_index <= CFG_FRAME_WIDTH;
      cfg_data <= word;
      do @(posedge clk); while (!cfg_ready);
      cur_w = (width == 0) ? 1 : (width > DEFAULT_MAX_WIDTH) ? DEFAULT_MAX_WIDTH : width;
    end
    if (set_height) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_FRAME_HEIGHT;
      cfg_data <= height;
      do @(posedge clk); while (!cfg_ready);
      cur_h = (height == 0) ? 1 : (height > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height;
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_frame(int pause_at);
    for (int i = 0; i < cur_w * cur_h; i++) begin
      if (i == pause_at) wait_drained();
      send_item(($urandom_range(0, 19) == 0) ? OP_FLUSH : OP_PIXEL,
                8'($urandom), 8'($urandom), 8'($urandom));
    end
    for (int i = 0; i <= cur_w; i++)
      send_item(($urandom_range(0, 19) == 0) ? OP_PIXEL : OP_FLUSH,
                8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic send_noise(int unsigned count);
    repeat (count)
      send_item(1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  initial begin
    int unsigned served, gap;
    served = 0;
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_requests != served) begin
        served++;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  initial begin
    #50000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int unsigned start;
    bit need_config, held, paused, holding;
    sb = new();
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    operation = OP_PIXEL;
    in_red = '0;
    in_green = '0;
    in_blue = '0;
    steady = 1'b0;
    items_sent = 0;
    hold_requests = 0;
    cur_w = RESET_FRAME_WIDTH;
    cur_h = RESET_FRAME_HEIGHT;
    need_config = 1'b1;
    held = 1'b0;
    paused = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // A 3x3 frame covers corners, edges and the center; the center request
    // is a flush, so it must count as black, and a pixel among the trailing
    // flush requests must be ignored.
    configure(1'b1, 11'd3, 1'b1, 13'd3);
    for (int k = 0; k < 9; k++) begin
      if (k == 4) send_item(OP_FLUSH, 8'hAA, 8'hAA, 8'hAA);
      else send_item(OP_PIXEL, 8'(k * 31), 8'(255 - k * 31), (k % 2 == 1) ? 8'hFF : 8'h00);
    end
    send_item(OP_FLUSH, 8'h00, 8'h00, 8'h00);
    send_item(OP_FLUSH, 8'hFF, 8'hFF, 8'hFF);
    send_item(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    send_item(OP_FLUSH, 8'h00, 8'h00, 8'h00);
    wait_drained();

    // Zero width and height both act as one.
    configure(1'b1, 11'd0, 1'b1, 13'd0);
    send_item(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    send_item(OP_FLUSH, 8'h00, 8'h00, 8'h00);
    send_item(OP_PIXEL, 8'h5A, 8'hA5, 8'h3C);
    wait_drained();

    // An oversized width is clamped to the line store size.
    configure(1'b1, 11'h7FF, 1'b1, 13'd1);
    repeat (DEFAULT_MAX_WIDTH + 6)
      send_item(OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
    wait_drained();
    configure(1'b1, 11'd1, 1'b1, 13'h1FFF);
    repeat (20) send_item(OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
    wait_drained();

    start = items_sent;
    while (items_sent - start < 380) begin
      holding = !held && (items_sent - start > 100);
      if (need_config || holding || $urandom_range(0, 2) == 0) begin
        wait_drained();
        if (holding) configure(1'b1, 11'd8, 1'b1, 13'd6);
        else configure(need_config || $urandom_range(0, 1) == 1, pick_width(),
                       need_config || $urandom_range(0, 1) == 1, pick_height());
        need_config = 1'b0;
      end
      steady = holding || ($urandom_range(0, 4) == 0);
      if (holding) begin
        held = 1'b1;
        hold_requests <= hold_requests + 1;
        send_frame(-1);
      end else if ($urandom_range(0, 9) == 0) begin
        send_noise($urandom_range(1, cur_w * cur_h + cur_w + 1));
        need_config = 1'b1;
      end else if (!paused && items_sent - start > 200) begin
        paused = 1'b1;
        send_frame(int'(cur_w * cur_h / 2));
      end else begin
        send_frame(-1);
      end
    end
    steady = 1'b0;
    wait_drained();
    sb.report_leftovers();
    if (sb.failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
